// File: design/prd_pkg.sv
// Shared types and constants for the port range demultiplexer.
`timescale 1ns / 1ps

package prd_pkg;

    // Number of port range registers.
    localparam int RANGES = 4;

    // Protocol numbers that are classified by port.
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Field widths.
    localparam int PROTO_W  = 8;
    localparam int PORT_W   = 16;
    localparam int GATE_W   = 16;
    localparam int COUNT_W  = 3;
    localparam int RANGE_W  = 48;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // Layout of a range register.
    localparam int START_LSB = 0;
    localparam int END_LSB   = 16;
    localparam int GATE_LSB  = 32;

    // Register map: one register per 8 bytes.
    localparam int REG_RANGE_COUNT   = 0;
    localparam int REG_FALLBACK_GATE = 1;
    localparam int REG_RANGE_BASE    = 2;
    localparam int CFG_REGS          = REG_RANGE_BASE + RANGES;
    localparam int CFG_REG_LIMIT     = 6;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_ADDR_W        = $clog2(CFG_REGS * 8);
    localparam int CFG_IDX_W         = CFG_ADDR_W - 3;

    // Decision queue between classifier and result generator.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [COUNT_W-1:0]             range_count;
        logic [GATE_W-1:0]              fallback_gate;
        logic [RANGES-1:0][RANGE_W-1:0] ranges;
    } cfg_t;

    // One classified packet: the final gate and the ranges that get a copy first.
    typedef struct packed {
        logic [GATE_W-1:0] gate;
        logic [RANGES-1:0] copy_mask;
    } entry_t;

    function automatic logic [GATE_W-1:0] range_gate(input logic [RANGE_W-1:0] r);
        range_gate = r[GATE_LSB +: GATE_W];
    endfunction

endpackage

// File: design/prd_front.sv
// Front end: accepts packet headers and classifies them into queue entries.
`timescale 1ns / 1ps

module prd_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  prd_pkg::cfg_t                  cfg,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [prd_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           q_valid,
    input  logic                           q_ready,
    output prd_pkg::entry_t                q_entry
);

    logic                          valid_reg;
    logic                          valid_next;
    prd_pkg::entry_t               entry_reg;
    prd_pkg::entry_t               entry_next;
    logic [prd_pkg::PROTO_W-1:0]   proto;
    logic [prd_pkg::PORT_W-1:0]    port;
    logic [prd_pkg::RANGES-1:0]    in_use;
    logic [prd_pkg::GATE_W-1:0]    uni_gate;
    logic [prd_pkg::RANGES-1:0]    bc_mask;
    logic                          is_l4;
    logic                          load;

    assign proto = s_tdata[prd_pkg::PROTO_W-1:0];
    assign port  = s_tdata[prd_pkg::PROTO_W +: prd_pkg::PORT_W];
    assign is_l4 = (proto == prd_pkg::PROTO_TCP) || (proto == prd_pkg::PROTO_UDP);

    always_comb begin
        for (int i = 0; i < prd_pkg::RANGES; i++) begin
            in_use[i] = 32'(cfg.range_count) > i;
        end
    end

    // First matching range wins: walk from the top so lower ranges override.
    always_comb begin
        uni_gate = cfg.fallback_gate;
        for (int i = prd_pkg::RANGES - 1; i >= 0; i--) begin
            if (in_use[i]
                && port >= cfg.ranges[i][prd_pkg::START_LSB +: prd_pkg::PORT_W]
                && port <  cfg.ranges[i][prd_pkg::END_LSB +: prd_pkg::PORT_W]) begin
                uni_gate = prd_pkg::range_gate(cfg.ranges[i]);
            end
        end
    end

    // A range makes a copy when its gate is new and differs from the default.
    always_comb begin
        for (int i = 0; i < prd_pkg::RANGES; i++) begin
            bc_mask[i] = in_use[i]
                && (prd_pkg::range_gate(cfg.ranges[i]) != cfg.fallback_gate);
            for (int j = 0; j < i; j++) begin
                if (prd_pkg::range_gate(cfg.ranges[j]) == prd_pkg::range_gate(cfg.ranges[i])) begin
                    bc_mask[i] = 1'b0;
                end
            end
        end
    end

    assign s_tready = !valid_reg || q_ready;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (load) begin
            valid_next = 1'b1;
            if (is_l4) begin
                entry_next.gate      = uni_gate;
                entry_next.copy_mask = '0;
            end else begin
                entry_next.gate      = cfg.fallback_gate;
                entry_next.copy_mask = bc_mask;
            end
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign q_valid = valid_reg;
    assign q_entry = entry_reg;

endmodule

// File: design/prd_queue.sv
// Short queue of classified packets between front end and result generator.
`timescale 1ns / 1ps

module prd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  prd_pkg::entry_t in_entry,
    output logic            out_valid,
    input  logic            out_ready,
    output prd_pkg::entry_t out_entry
);

    prd_pkg::entry_t               slots_reg [prd_pkg::QUEUE_DEPTH];
    logic [prd_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [prd_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [prd_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [prd_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [prd_pkg::QCNT_W-1:0]    count_reg;
    logic [prd_pkg::QCNT_W-1:0]    count_next;
    logic                          push;
    logic                          pop;

    assign in_ready  = count_reg != prd_pkg::QCNT_W'(prd_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_entry = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    function automatic logic [prd_pkg::QPTR_W-1:0] bump(input logic [prd_pkg::QPTR_W-1:0] p);
        if (32'(p) == prd_pkg::QUEUE_DEPTH - 1) begin
            bump = '0;
        end else begin
            bump = p + 1'b1;
        end
    endfunction

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slots_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

// File: design/prd_back.sv
// Back end: expands each queue entry into its copy words and final word.
`timescale 1ns / 1ps

module prd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  prd_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  prd_pkg::entry_t               q_entry,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [prd_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic                          active_reg;
    logic                          active_next;
    logic [prd_pkg::RANGES-1:0]    rem_reg;
    logic [prd_pkg::RANGES-1:0]    rem_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [prd_pkg::GATE_W-1:0]    gate_reg;
    logic [prd_pkg::GATE_W-1:0]    gate_next;
    logic                          copy_reg;
    logic                          copy_next;
    logic                          last_reg;
    logic                          last_next;
    logic [prd_pkg::RANGES-1:0]    mask;
    logic [prd_pkg::RANGES-1:0]    low_bit;
    logic [prd_pkg::GATE_W-1:0]    copy_gate;
    logic                          advance;

    // Once the first copy of an entry is out, the remaining copies come from rem_reg.
    assign mask    = active_reg ? rem_reg : q_entry.copy_mask;
    assign low_bit = mask & (~mask + 1'b1);
    assign advance = !valid_reg || m_tready;

    always_comb begin
        copy_gate = '0;
        for (int i = 0; i < prd_pkg::RANGES; i++) begin
            if (low_bit[i]) begin
                copy_gate = copy_gate | prd_pkg::range_gate(cfg.ranges[i]);
            end
        end
    end

    always_comb begin
        active_next = active_reg;
        rem_next    = rem_reg;
        valid_next  = valid_reg;
        gate_next   = gate_reg;
        copy_next   = copy_reg;
        last_next   = last_reg;
        q_ready     = 1'b0;
        if (advance) begin
            valid_next = q_valid;
            if (q_valid) begin
                if (mask != '0) begin
                    gate_next   = copy_gate;
                    copy_next   = 1'b1;
                    last_next   = 1'b0;
                    rem_next    = mask & ~low_bit;
                    active_next = 1'b1;
                end else begin
                    gate_next   = q_entry.gate;
                    copy_next   = 1'b0;
                    last_next   = 1'b1;
                    active_next = 1'b0;
                    q_ready     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
        rem_reg  <= rem_next;
        gate_reg <= gate_next;
        copy_reg <= copy_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = gate_reg;
    assign m_tuser  = copy_reg;
    assign m_tlast  = last_reg;

endmodule

// File: design/port_range_demultiplexer.sv
// Top level of the port range demultiplexer: register file and pipeline.
//
// The input stream carries one packet header per word: s_tdata holds the IPv4
// protocol number and the L4 destination port. A TCP or UDP packet gives one
// result word with the gate of the first matching range, or the default gate.
// Any other protocol gives one copy word per distinct range gate that differs
// from the default, then a final word for the default gate.
// Result words carry the gate in m_tdata, the copy flag in m_tuser and the
// final-word flag in m_tlast.
// m_tvalid rises once the word has passed the classifier register, the queue
// and the result register. A unicast packet gives one word, a broadcast packet
// one word per copy plus a final word; the result generator emits one word per cycle while m_tready is high.
// Input is accepted every cycle while the two-entry queue and the classifier
// register have room, so a stalled receiver backs up only once they are full.
// Reset clears the configuration registers to zero and empties the pipeline.
// The APB port places register i at byte address 8*i; write it only while idle.
`timescale 1ns / 1ps

module port_range_demultiplexer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [prd_pkg::S_DATA_W-1:0]     s_tdata,   // ip_protocol[7:0], l4_port[23:8]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [prd_pkg::M_DATA_W-1:0]     m_tdata,   // gate[15:0]
    output logic                             m_tuser,   // is_copy[0]
    output logic                             m_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [prd_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [prd_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [prd_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    prd_pkg::cfg_t                   cfg_reg;
    prd_pkg::cfg_t                   cfg_next;
    logic [prd_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic                            wr_en;
    logic                            fq_valid;
    logic                            fq_ready;
    prd_pkg::entry_t                 fq_entry;
    logic                            qb_valid;
    logic                            qb_ready;
    prd_pkg::entry_t                 qb_entry;

    assign pready  = 1'b1;
    assign reg_idx = paddr[prd_pkg::CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            if (32'(reg_idx) == prd_pkg::REG_RANGE_COUNT) begin
                cfg_next.range_count = pwdata[prd_pkg::COUNT_W-1:0];
            end else if (32'(reg_idx) == prd_pkg::REG_FALLBACK_GATE) begin
                cfg_next.fallback_gate = pwdata[prd_pkg::GATE_W-1:0];
            end
            for (int i = 0; i < prd_pkg::RANGES; i++) begin
                if (32'(reg_idx) == prd_pkg::REG_RANGE_BASE + i
                    && prd_pkg::REG_RANGE_BASE + i < prd_pkg::CFG_REG_LIMIT) begin
                    cfg_next.ranges[i] = pwdata[prd_pkg::RANGE_W-1:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (32'(reg_idx) == prd_pkg::REG_RANGE_COUNT) begin
            prdata = prd_pkg::CFG_DATA_W'(cfg_reg.range_count);
        end else if (32'(reg_idx) == prd_pkg::REG_FALLBACK_GATE) begin
            prdata = prd_pkg::CFG_DATA_W'(cfg_reg.fallback_gate);
        end
        for (int i = 0; i < prd_pkg::RANGES; i++) begin
            if (32'(reg_idx) == prd_pkg::REG_RANGE_BASE + i
                && prd_pkg::REG_RANGE_BASE + i < prd_pkg::CFG_REG_LIMIT) begin
                prdata = prd_pkg::CFG_DATA_W'(cfg_reg.ranges[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    prd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_entry  (fq_entry)
    );

    prd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_entry  (fq_entry),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_entry (qb_entry)
    );

    prd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (qb_valid),
        .q_ready  (qb_ready),
        .q_entry  (qb_entry),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/tb_port_range_demultiplexer.sv
// Self-checking testbench for the port range demultiplexer: directed table, then random packets.
`timescale 1ns / 1ps

module tb_port_range_demultiplexer;
    import prd_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int RANDOM_PHASES     = 6;
    localparam int PACKETS_PER_PHASE = 45;
    localparam int LONG_HOLD         = 80;
    localparam int SETTLE            = 8;
    localparam int NPROBES           = 25;
    localparam int MAX_REPORTS       = 10;

    typedef struct packed {
        logic [GATE_W-1:0] gate;
        logic              is_copy;
        logic              last;
    } gate_word_t;

    typedef struct packed {
        logic [1:0]         cfg_set;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  port;
        logic               known;
        logic [GATE_W-1:0]  known_gate;
    } probe_t;

    typedef enum {RX_READY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    // Rows of the first set run right after reset, so every packet lands on gate zero.
    localparam probe_t PROBES [NPROBES] = '{
        '{2'd0, PROTO_TCP, 16'd0,     1'b1, 16'd0},
        '{2'd0, PROTO_UDP, 16'd65535, 1'b1, 16'd0},
        '{2'd0, 8'd0,      16'd0,     1'b1, 16'd0},
        '{2'd0, 8'd255,    16'd65535, 1'b1, 16'd0},
        '{2'd1, PROTO_TCP, 16'd99,    1'b0, 16'd0},
        '{2'd1, PROTO_TCP, 16'd100,   1'b0, 16'd0},
        '{2'd1, PROTO_UDP, 16'd150,   1'b0, 16'd0},
        '{2'd1, PROTO_TCP, 16'd199,   1'b0, 16'd0},
        '{2'd1, PROTO_UDP, 16'd200,   1'b0, 16'd0},
        '{2'd1, PROTO_TCP, 16'd299,   1'b0, 16'd0},
        '{2'd1, PROTO_TCP, 16'd300,   1'b0, 16'd0},
        '{2'd1, PROTO_UDP, 16'd500,   1'b0, 16'd0},
        '{2'd1, PROTO_TCP, 16'd65535, 1'b0, 16'd0},
        '{2'd1, 8'd1,      16'd150,   1'b0, 16'd0},
        '{2'd1, 8'd255,    16'd0,     1'b0, 16'd0},
        '{2'd1, 8'd7,      16'd100,   1'b0, 16'd0},
        '{2'd1, 8'd16,     16'd200,   1'b0, 16'd0},
        '{2'd2, PROTO_TCP, 16'd65535, 1'b0, 16'd0},
        '{2'd2, PROTO_UDP, 16'd0,     1'b0, 16'd0},
        '{2'd2, PROTO_TCP, 16'd65534, 1'b0, 16'd0},
        '{2'd2, 8'd0,      16'd65535, 1'b0, 16'd0},
        '{2'd2, 8'd18,     16'd1,     1'b0, 16'd0},
        '{2'd3, PROTO_UDP, 16'd0,     1'b0, 16'd0},
        '{2'd3, PROTO_TCP, 16'd65535, 1'b0, 16'd0},
        '{2'd3, 8'd128,    16'd0,     1'b0, 16'd0}
    };

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;     // ip_protocol[7:0], l4_port[23:8]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;           // gate[15:0]
    logic                  m_tuser;           // is_copy[0]
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Shadow copy of the register file, updated as each write completes.
    logic [COUNT_W-1:0] cfg_count   = '0;
    logic [GATE_W-1:0]  cfg_default = '0;
    logic [RANGE_W-1:0] cfg_range [RANGES];

    gate_word_t pending_gates [$];
    gate_word_t want;
    int         mismatches    = 0;
    int         cycle_count   = 0;
    int         burst_left    = 0;
    bit         long_hold_req = 1'b0;

    port_range_demultiplexer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Works out the result words one packet must produce under the current registers.
    function automatic void classify_packet(input logic [PROTO_W-1:0] proto,
                                            input logic [PORT_W-1:0] port);
        int                n;
        logic [GATE_W-1:0] g;
        logic [PORT_W-1:0] lo;
        logic [PORT_W-1:0] hi;
        logic              hit;
        logic              seen;
        n = (int'(cfg_count) > RANGES) ? RANGES : int'(cfg_count);
        if (proto == PROTO_TCP || proto == PROTO_UDP) begin
            g   = cfg_default;
            hit = 1'b0;
            for (int i = 0; i < n; i++) begin
                lo = cfg_range[i][START_LSB +: PORT_W];
                hi = cfg_range[i][END_LSB +: PORT_W];
                if (!hit && port >= lo && port < hi) begin
                    g   = cfg_range[i][GATE_LSB +: GATE_W];
                    hit = 1'b1;
                end
            end
            pending_gates.push_back('{g, 1'b0, 1'b1});
        end else begin
            for (int i = 0; i < n; i++) begin
                g    = cfg_range[i][GATE_LSB +: GATE_W];
                seen = (g == cfg_default);
                for (int j = 0; j < i; j++) begin
                    if (cfg_range[j][GATE_LSB +: GATE_W] == g) seen = 1'b1;
                end
                if (!seen) pending_gates.push_back('{g, 1'b1, 1'b0});
            end
            pending_gates.push_back('{cfg_default, 1'b0, 1'b1});
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] range_word(input logic [GATE_W-1:0] gate,
                                                         input logic [PORT_W-1:0] hi,
                                                         input logic [PORT_W-1:0] lo);
        return {{(CFG_DATA_W - RANGE_W){1'b0}}, gate, hi, lo};
    endfunction

    // Small gate values are favored so that repeats and default collisions are common.
    function automatic logic [GATE_W-1:0] pick_gate();
        if ($urandom_range(0, 3) != 0) return GATE_W'($urandom_range(0, 3));
        return GATE_W'($urandom);
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic offer_word(input logic [PROTO_W-1:0] proto, input logic [PORT_W-1:0] port);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {port, proto};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_gates.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_RANGE_COUNT) begin
            cfg_count = value[COUNT_W-1:0];
        end else if (idx == REG_FALLBACK_GATE) begin
            cfg_default = value[GATE_W-1:0];
        end else if (idx >= REG_RANGE_BASE && idx < REG_RANGE_BASE + RANGES) begin
            cfg_range[idx - REG_RANGE_BASE] = value[RANGE_W-1:0];
        end
    endtask

    task automatic load_directed_set(input int set_id);
        case (set_id)
            1: begin
                // Overlap where the first range wins, an empty range that repeats gate 1,
                // and an inverted range whose gate equals the default.
                write_reg(REG_RANGE_COUNT, 64'd4);
                write_reg(REG_FALLBACK_GATE, 64'hFFFF);
                write_reg(REG_RANGE_BASE + 0, range_word(16'd1, 16'd200, 16'd100));
                write_reg(REG_RANGE_BASE + 1, range_word(16'd2, 16'd300, 16'd150));
                write_reg(REG_RANGE_BASE + 2, range_word(16'd1, 16'd500, 16'd500));
                write_reg(REG_RANGE_BASE + 3, range_word(16'hFFFF, 16'd0, 16'hFFFF));
            end
            2: begin
                // A count above the number of ranges behaves as the full set,
                // and bits above each register's width are dropped.
                write_reg(REG_RANGE_COUNT, 64'd7);
                write_reg(REG_FALLBACK_GATE, 64'hFFFF_FFFF_FFFF_0000);
                write_reg(REG_RANGE_BASE + 0,
                          range_word(16'd5, 16'hFFFF, 16'd0) | 64'hDEAD_0000_0000_0000);
                write_reg(REG_RANGE_BASE + 1, range_word(16'd0, 16'hFFFF, 16'hFFFE));
                write_reg(REG_RANGE_BASE + 2, range_word(16'd6, 16'd0, 16'd0));
                write_reg(REG_RANGE_BASE + 3, range_word(16'd5, 16'hFFFF, 16'd0));
                // Writes past the last register must leave everything alone.
                write_reg(CFG_REGS, {CFG_DATA_W{1'b1}});
                write_reg(CFG_REGS + 1, {CFG_DATA_W{1'b1}});
            end
            3: begin
                write_reg(REG_RANGE_COUNT, 64'd1);
                write_reg(REG_FALLBACK_GATE, 64'hA5A5);
            end
            default: ;
        endcase
    endtask

    task automatic load_random_set();
        logic [CFG_DATA_W-1:0] w;
        logic [PORT_W-1:0]     lo;
        logic [PORT_W-1:0]     hi;
        logic [PORT_W-1:0]     t;
        w = {$urandom, $urandom};
        w[COUNT_W-1:0] = COUNT_W'($urandom_range(0, 7));
        write_reg(REG_RANGE_COUNT, w);
        w = {$urandom, $urandom};
        w[GATE_W-1:0] = pick_gate();
        write_reg(REG_FALLBACK_GATE, w);
        for (int i = 0; i < RANGES; i++) begin
            lo = PORT_W'($urandom);
            hi = PORT_W'($urandom);
            if ($urandom_range(0, 3) != 0 && lo > hi) begin
                t  = lo;
                lo = hi;
                hi = t;
            end
            if ($urandom_range(0, 2) == 0) hi = lo + PORT_W'($urandom_range(0, 300));
            if ($urandom_range(0, 7) == 0) lo = '0;
            if ($urandom_range(0, 7) == 0) hi = '1;
            w = {$urandom, $urandom};
            w[RANGE_W-1:0] = {pick_gate(), hi, lo};
            write_reg(REG_RANGE_BASE + i, w);
        end
    endtask

    // Mostly TCP or UDP ports placed on or next to a range edge; the rest broadcasts.
    task automatic random_packet();
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  port;
        logic [PORT_W-1:0]  lo;
        logic [PORT_W-1:0]  hi;
        int                 k;
        if ($urandom_range(0, 9) < 7) begin
            proto = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
            k  = $urandom_range(0, RANGES - 1);
            lo = cfg_range[k][START_LSB +: PORT_W];
            hi = cfg_range[k][END_LSB +: PORT_W];
            case ($urandom_range(0, 5))
                0: port = lo - 16'd1;
                1: port = lo;
                2: port = hi - 16'd1;
                3: port = hi;
                4: port = lo + PORT_W'($urandom_range(0, 255));
                default: port = PORT_W'($urandom);
            endcase
        end else begin
            proto = PROTO_W'($urandom);
            port  = PORT_W'($urandom);
        end
        classify_packet(proto, port);
        offer_word(proto, port);
    endtask

    initial begin : stimulus
        int cur_set;
        for (int i = 0; i < RANGES; i++) cfg_range[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        cur_set = 0;
        for (int i = 0; i < NPROBES; i++) begin
            if (int'(PROBES[i].cfg_set) != cur_set) begin
                wait_idle();
                cur_set = int'(PROBES[i].cfg_set);
                load_directed_set(cur_set);
            end
            if (PROBES[i].known) begin
                pending_gates.push_back('{PROBES[i].known_gate, 1'b0, 1'b1});
            end else begin
                classify_packet(PROBES[i].proto, PROBES[i].port);
            end
            offer_word(PROBES[i].proto, PROBES[i].port);
        end
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            load_random_set();
            if (p == 2) long_hold_req = 1'b1;
            repeat (PACKETS_PER_PHASE) random_packet();
        end
        wait_idle();
        if (mismatches == 0 && pending_gates.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // The receiver runs stretches of steady, random and periodic readiness,
    // and once backs off long enough for the block to fill and stall its input.
    initial begin : rx_pacing
        rx_mode_t mode;
        int       stretch_left;
        int       duty;
        int       period;
        int       hold_left;
        int       tick;
        mode         = RX_READY;
        stretch_left = 0;
        duty         = 50;
        period       = 3;
        hold_left    = 0;
        tick         = 0;
        forever begin
            @(posedge aclk);
            tick++;
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (stretch_left == 0) begin
                mode         = rx_mode_t'($urandom_range(0, 2));
                stretch_left = $urandom_range(8, 64);
                duty         = $urandom_range(20, 90);
                period       = $urandom_range(2, 5);
            end
            stretch_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (mode == RX_READY) begin
                m_tready <= 1'b1;
            end else if (mode == RX_RANDOM) begin
                m_tready <= ($urandom_range(0, 99) < duty);
            end else begin
                m_tready <= (tick % period) != 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_gates.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: gate %h copy %b last %b",
                             m_tdata, m_tuser, m_tlast);
            end else begin
                want = pending_gates.pop_front();
                if (m_tdata !== want.gate || m_tuser !== want.is_copy ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected gate %h copy %b last %b, got %h %b %b",
                                 want.gate, want.is_copy, want.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// File: port_range_demultiplexer.f
design/prd_pkg.sv
design/prd_front.sv
design/prd_queue.sv
design/prd_back.sv
design/port_range_demultiplexer.sv
tb/tb_port_range_demultiplexer.sv
